// ----- rtl/rlp_item_encoder_defines.svh -----
// Assertion macros used by the encoder's output shifter (rlpe_serial).
`ifndef RLP_ITEM_ENCODER_DEFINES_SVH
`define RLP_ITEM_ENCODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RLPE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rlpe assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RLPE_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rlpe assertion failed");

`endif

// ----- rtl/rlpe_pkg.sv -----
package rlpe_pkg;

   localparam int VAL_W = 64;

   localparam logic [1:0] OP_STRING = 2'd0;
   localparam logic [1:0] OP_LIST   = 2'd1;
   localparam logic [1:0] OP_INT    = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [7:0]  STR_BASE    = 8'h80;
   localparam logic [7:0]  LIST_BASE   = 8'hc0;
   localparam logic [7:0]  STR_LONG    = 8'hb7;
   localparam logic [7:0]  LIST_LONG   = 8'hf7;
   localparam logic [31:0] SHORT_LIMIT = 32'd56;

   typedef enum logic [1:0] {
      KIND_ONE,
      KIND_TWO,
      KIND_LONG
   } kind_type;

   typedef struct packed {
      kind_type         kind;
      logic [7:0]       b0;
      logic [7:0]       b1;
      logic [VAL_W-1:0] val;
      logic             tail;
   } s1_type;

   typedef struct packed {
      kind_type         kind;
      logic [7:0]       b0;
      logic [7:0]       b1;
      logic [VAL_W-1:0] val;
      logic             tail;
      logic [3:0]       n;
   } s2_type;

endpackage

// ----- rtl/rlpe_decode.sv -----
module rlpe_decode
   import rlpe_pkg::*;
#(
   parameter int LENGTH_BYTES = 4,
   parameter int INT_BYTES    = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,
   input  logic [2:0]   req_tuser,
   output logic         s1_valid,
   output s1_type       s1,
   input  logic         s1_ready
);

   logic         s1_valid_ff;
   logic         s1_valid_in;
   s1_type       s1_ff;
   s1_type       s1_in;
   logic [1:0]   op;
   logic         first;
   logic [31:0]  len_m;
   logic [7:0]   db;
   logic [63:0]  iv_m;
   logic [7:0]   base;
   logic [7:0]   lbase;

   assign req_tready = !s1_valid_ff || s1_ready;
   assign op         = req_tuser[1:0];
   assign first      = req_tuser[2];
   assign db         = req_tdata[39:32];
   assign base       = (op == OP_STRING) ? STR_BASE : LIST_BASE;
   assign lbase      = (op == OP_STRING) ? STR_LONG : LIST_LONG;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         len_m[8*i +: 8] = (i < LENGTH_BYTES) ? req_tdata[8*i +: 8] : 8'h00;
      end
      for (int i = 0; i < 8; i++) begin
         iv_m[8*i +: 8] = (i < INT_BYTES) ? req_tdata[40 + 8*i +: 8] : 8'h00;
      end
   end

   always_comb begin
      s1_in      = '0;
      s1_in.kind = KIND_ONE;
      s1_in.b0   = db;
      s1_in.b1   = db;
      case (op)
         OP_INT: begin
            if (iv_m == 64'd0) begin
               s1_in.b0 = STR_BASE;
            end else if (iv_m < 64'h80) begin
               s1_in.b0 = iv_m[7:0];
            end else begin
               s1_in.kind = KIND_LONG;
               s1_in.b0   = STR_BASE;
               s1_in.val  = iv_m;
            end
         end
         OP_STRING, OP_LIST: begin
            if (!first) begin
               s1_in.b0 = db;
            end else if (op == OP_STRING && len_m == 32'd1 && db < STR_BASE) begin
               s1_in.b0 = db;
            end else if (len_m == 32'd0) begin
               s1_in.b0 = base;
            end else if (len_m < SHORT_LIMIT) begin
               s1_in.kind = KIND_TWO;
               s1_in.b0   = base + len_m[7:0];
            end else begin
               s1_in.kind = KIND_LONG;
               s1_in.b0   = lbase;
               s1_in.val  = {32'h0, len_m};
               s1_in.tail = 1'b1;
            end
         end
         default: begin
            s1_in.b0 = db;
         end
      endcase
   end

   // An unused operation is taken from the bus and dropped here.
   assign s1_valid_in = req_tvalid && (op != OP_UNUSED);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         s1_ff <= s1_in;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1       = s1_ff;

endmodule

// ----- rtl/rlpe_count.sv -----
module rlpe_count
   import rlpe_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   s1_valid,
   input  s1_type s1,
   output logic   s1_ready,
   output logic   s2_valid,
   output s2_type s2,
   input  logic   s2_ready
);

   logic       s2_valid_ff;
   s2_type     s2_ff;
   s2_type     s2_in;
   logic [3:0] n;

   assign s1_ready = !s2_valid_ff || s2_ready;

   // Minimal byte count of the value: position of its highest nonzero byte.
   always_comb begin
      n = 4'd0;
      for (int i = 0; i < 8; i++) begin
         if (s1.val[8*i +: 8] != 8'h00) begin
            n = 4'(i + 1);
         end
      end
   end

   always_comb begin
      s2_in.kind = s1.kind;
      s2_in.b0   = (s1.kind == KIND_LONG) ? s1.b0 + {4'h0, n} : s1.b0;
      s2_in.b1   = s1.b1;
      s2_in.val  = s1.val;
      s2_in.tail = s1.tail;
      s2_in.n    = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s2_valid_ff <= s1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s2_ff <= s2_in;
      end
   end

   assign s2_valid = s2_valid_ff;
   assign s2       = s2_ff;

endmodule

// ----- rtl/rlpe_serial.sv -----
`include "rlp_item_encoder_defines.svh"

module rlpe_serial
   import rlpe_pkg::*;
#(
   parameter int MAX_OUT = 9
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       s2_valid,
   input  s2_type     s2,
   output logic       s2_ready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic       rsp_tlast
);

   localparam int CNT_W = $clog2(MAX_OUT + 1);

   logic [7:0]       obuf_ff [MAX_OUT];
   logic [7:0]       obuf_in [MAX_OUT];
   logic [7:0]       fresh   [MAX_OUT];
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic [CNT_W-1:0] fresh_cnt;
   logic [5:0]       shamt;
   logic [2:0]       gap;
   logic [71:0]      wide;
   logic             fire;
   logic             take;

   assign fire     = rsp_tvalid && rsp_tready;
   assign s2_ready = (cnt_ff == '0) || (fire && cnt_ff == CNT_W'(1));
   assign take     = s2_valid && s2_ready;

   // Align the value's significant bytes to the top for big-endian output.
   assign gap   = 3'(4'd8 - s2.n);
   assign shamt = {gap, 3'b000};
   assign wide  = {s2.val << shamt, 8'h00};

   always_comb begin
      for (int j = 0; j < MAX_OUT; j++) begin
         fresh[j] = 8'h00;
      end
      fresh[0]  = s2.b0;
      fresh_cnt = CNT_W'(1);
      case (s2.kind)
         KIND_ONE: begin
            fresh_cnt = CNT_W'(1);
         end
         KIND_TWO: begin
            fresh[1]  = s2.b1;
            fresh_cnt = CNT_W'(2);
         end
         KIND_LONG: begin
            for (int i = 0; i < MAX_OUT - 1; i++) begin
               if (4'(i) < s2.n) begin
                  fresh[i + 1] = wide[71 - 8*i -: 8];
               end else if (s2.tail && 4'(i) == s2.n) begin
                  fresh[i + 1] = s2.b1;
               end
            end
            fresh_cnt = CNT_W'(1) + CNT_W'(s2.n) + CNT_W'(s2.tail);
         end
         default: begin
            fresh_cnt = CNT_W'(1);
         end
      endcase
   end

   always_comb begin
      obuf_in = obuf_ff;
      cnt_in  = cnt_ff;
      if (take) begin
         obuf_in = fresh;
         cnt_in  = fresh_cnt;
      end else if (fire) begin
         for (int j = 0; j < MAX_OUT - 1; j++) begin
            obuf_in[j] = obuf_ff[j + 1];
         end
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      obuf_ff <= obuf_in;
   end

   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_tdata  = obuf_ff[0];
   assign rsp_tlast  = (cnt_ff == CNT_W'(1));

   `RLPE_ASSERT_IMP(a_cnt_range, clock, reset, 1'b1, cnt_ff <= CNT_W'(MAX_OUT))
   `RLPE_ASSERT_NXT(a_long_cnt, clock, reset, take && s2.kind == KIND_LONG, cnt_ff >= CNT_W'(2))
   `RLPE_ASSERT_NXT(a_drain, clock, reset, fire && rsp_tlast && !take, !rsp_tvalid)

endmodule

// ----- rtl/rlp_item_encoder.sv -----
// Streaming RLP encoder. Each input word is an element of a byte string or a
// list payload, or a whole integer, and yields one to MAX_OUT output words
// (one byte each), with tlast on the final byte of that input. The pipeline
// has three register stages (decode, byte count, output shifter); an input
// word is accepted every cycle while the output shifter is empty or is
// handing over its last pending byte, so sustained throughput is one output
// byte per cycle while the receiver accepts. An accepted word passes through
// the decode and byte-count registers into the output shifter. Input words
// with the unused operation code are accepted and produce no output.
module rlp_item_encoder
   import rlpe_pkg::*;
#(
   parameter int LENGTH_BYTES = 4,
   parameter int INT_BYTES    = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,  // total_length, data_byte, int_value
   input  logic [2:0]   req_tuser,  // operation, first
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,  // out_byte
   output logic         rsp_tlast
);

   localparam int MAX_OUT = (INT_BYTES + 1 > LENGTH_BYTES + 2) ?
                            INT_BYTES + 1 : LENGTH_BYTES + 2;

   logic   s1_valid;
   logic   s1_ready;
   s1_type s1;
   logic   s2_valid;
   logic   s2_ready;
   s2_type s2;

   rlpe_decode #(
      .LENGTH_BYTES (LENGTH_BYTES),
      .INT_BYTES    (INT_BYTES)
   ) u_decode (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .s1_valid   (s1_valid),
      .s1         (s1),
      .s1_ready   (s1_ready)
   );

   rlpe_count u_count (
      .clock    (clock),
      .reset    (reset),
      .s1_valid (s1_valid),
      .s1       (s1),
      .s1_ready (s1_ready),
      .s2_valid (s2_valid),
      .s2       (s2),
      .s2_ready (s2_ready)
   );

   rlpe_serial #(
      .MAX_OUT (MAX_OUT)
   ) u_serial (
      .clock      (clock),
      .reset      (reset),
      .s2_valid   (s2_valid),
      .s2         (s2),
      .s2_ready   (s2_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- test/rlp_item_encoder_test.sv -----
module rlp_item_encoder_test
   import rlpe_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LENGTH_BYTES = 4;
   localparam int INT_BYTES    = 8;
   localparam int CYCLE_LIMIT  = 200000;

   typedef struct {
      logic [7:0] out_byte;
      logic       last_of_run;
   } rlp_byte_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [103:0] req_tdata = '0;  // total_length, data_byte, int_value
   logic [2:0]   req_tuser = '0;  // operation, first
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [7:0]   rsp_tdata;       // out_byte
   logic         rsp_tlast;

   rlp_byte_type pending_bytes[$];
   rlp_byte_type expected_byte;
   int           mismatches = 0;
   int           cycle_count = 0;
   int           sender_idle_pct = 0;
   int           receiver_stall_pct = 0;
   int           hold_left = 0;

   rlp_item_encoder #(
      .LENGTH_BYTES(LENGTH_BYTES),
      .INT_BYTES(INT_BYTES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [63:0] byte_mask(int nbytes);
      if (nbytes >= 8) return '1;
      return (64'd1 << (8 * nbytes)) - 64'd1;
   endfunction

   function automatic int byte_count(logic [63:0] v);
      int n;
      n = 0;
      while (v != 0 && n < 8) begin
         n++;
         v = v >> 8;
      end
      return n;
   endfunction

   function automatic void push_byte(logic [7:0] b);
      rlp_byte_type e;
      e.out_byte = b;
      e.last_of_run = 1'b0;
      pending_bytes.push_back(e);
   endfunction

   function automatic void push_be(logic [63:0] v, int n);
      for (int i = n; i > 0; i--) push_byte(v[8*(i-1) +: 8]);
   endfunction

   // Appends the encoded bytes of one input word to the expected stream.
   function automatic void encode_rlp(logic [1:0] op, logic first, logic [31:0] total_length,
                                      logic [7:0] data_byte, logic [63:0] int_value);
      logic [63:0] len;
      logic [63:0] v;
      logic [7:0]  base;
      int          n;
      int          start;
      len = {32'd0, total_length} & byte_mask(LENGTH_BYTES);
      v = int_value & byte_mask(INT_BYTES);
      start = pending_bytes.size();
      case (op)
         OP_UNUSED: return;
         OP_INT: begin
            if (v == 0) begin
               push_byte(STR_BASE);
            end else if (v < STR_BASE) begin
               push_byte(v[7:0]);
            end else begin
               n = byte_count(v);
               push_byte(STR_BASE + 8'(n));
               push_be(v, n);
            end
         end
         default: begin
            if (!first) begin
               push_byte(data_byte);
            end else if (op == OP_STRING && len == 1 && data_byte < STR_BASE) begin
               push_byte(data_byte);
            end else begin
               base = (op == OP_STRING) ? STR_BASE : LIST_BASE;
               if (len < SHORT_LIMIT) begin
                  push_byte(base + len[7:0]);
               end else begin
                  n = byte_count(len);
                  push_byte(((op == OP_STRING) ? STR_LONG : LIST_LONG) + 8'(n));
                  push_be(len, n);
               end
               if (len != 0) push_byte(data_byte);
            end
         end
      endcase
      if (pending_bytes.size() > start) pending_bytes[$].last_of_run = 1'b1;
   endfunction

   task automatic send_word(logic [1:0] op, logic first, logic [31:0] total_length,
                            logic [7:0] data_byte, logic [63:0] int_value);
      bit driven;
      driven = 0;
      while (!driven) begin
         @(negedge clock);
         if ($urandom_range(99) < sender_idle_pct) begin
            req_tvalid <= 1'b0;
         end else begin
            req_tvalid <= 1'b1;
            req_tdata <= {int_value, data_byte, total_length};
            req_tuser <= {first, op};
            driven = 1;
         end
      end
      do @(posedge clock); while (!req_tready);
      encode_rlp(op, first, total_length, data_byte, int_value);
   endtask

   function automatic logic [63:0] rand_int_value();
      int n;
      n = $urandom_range(8);
      return {$urandom, $urandom} & byte_mask(n);
   endfunction

   function automatic logic [31:0] rand_length();
      case ($urandom_range(6))
         0: return 32'd0;
         1: return 32'd1;
         2: return $urandom_range(55, 2);
         3: return $urandom_range(255, 56);
         4: return $urandom_range(65535, 256);
         5: return $urandom & 32'h00ff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // Sends one item (header word plus some payload words) or one stray word.
   task automatic send_random_sequence(output int counted);
      logic [1:0]  op;
      logic [31:0] len;
      int          follow;
      int          pick;
      counted = 0;
      pick = $urandom_range(99);
      if (pick < 35) begin
         op = $urandom_range(1) ? OP_LIST : OP_STRING;
         len = rand_length();
         send_word(op, 1'b1, len, 8'($urandom), {$urandom, $urandom});
         counted = 1;
         follow = $urandom_range(4);
         if (len == 0) follow = 0;
         else if (len - 1 < follow) follow = len - 1;
         for (int i = 0; i < follow; i++) begin
            send_word(op, 1'b0, $urandom, 8'($urandom), {$urandom, $urandom});
            counted++;
         end
      end else if (pick < 70) begin
         send_word(OP_INT, 1'($urandom), $urandom, 8'($urandom), rand_int_value());
         counted = 1;
      end else if (pick < 85) begin
         send_word(OP_STRING, 1'b1, 32'd1, 8'($urandom), {$urandom, $urandom});
         counted = 1;
      end else if (pick < 93) begin
         op = $urandom_range(1) ? OP_LIST : OP_STRING;
         send_word(op, 1'b0, $urandom, 8'($urandom), {$urandom, $urandom});
         counted = 1;
      end else begin
         send_word(OP_UNUSED, 1'($urandom), $urandom, 8'($urandom), {$urandom, $urandom});
      end
   endtask

   task automatic test_integers();
      send_word(OP_INT, 1'b0, 32'd0, 8'h00, 64'd0);
      send_word(OP_INT, 1'b1, 32'd7, 8'hff, 64'd1);
      send_word(OP_INT, 1'b0, 32'd0, 8'h00, 64'h7f);
      send_word(OP_INT, 1'b0, 32'd0, 8'h00, 64'h80);
      send_word(OP_INT, 1'b0, 32'd0, 8'h00, 64'h100);
      send_word(OP_INT, 1'b0, 32'd0, 8'h00, 64'h8000_0000_0000_0000);
      send_word(OP_INT, 1'b1, '1, 8'hff, '1);
   endtask

   task automatic test_strings();
      send_word(OP_STRING, 1'b1, 32'd0, 8'h55, 64'd0);
      send_word(OP_STRING, 1'b1, 32'd1, 8'h00, 64'd0);
      send_word(OP_STRING, 1'b1, 32'd1, 8'h7f, 64'd0);
      send_word(OP_STRING, 1'b1, 32'd1, 8'h80, 64'd0);
      send_word(OP_STRING, 1'b1, 32'd55, 8'hff, 64'd0);
      send_word(OP_STRING, 1'b1, 32'd56, 8'h12, 64'd0);
      send_word(OP_STRING, 1'b0, 32'd0, 8'hab, 64'd0);
      send_word(OP_STRING, 1'b1, '1, 8'h34, '1);
   endtask

   task automatic test_lists();
      send_word(OP_LIST, 1'b1, 32'd0, 8'h99, 64'd0);
      send_word(OP_LIST, 1'b1, 32'd1, 8'h05, 64'd0);
      send_word(OP_LIST, 1'b1, 32'd55, 8'hc3, 64'd0);
      send_word(OP_LIST, 1'b1, 32'd56, 8'h80, 64'd0);
      send_word(OP_LIST, 1'b1, 32'd256, 8'h01, 64'd0);
      send_word(OP_LIST, 1'b0, '1, 8'hfe, 64'd0);
   endtask

   task automatic test_unused_operation();
      send_word(OP_UNUSED, 1'b1, 32'd3, 8'h11, 64'd1);
      send_word(OP_UNUSED, 1'b0, '1, 8'hff, '1);
      send_word(OP_INT, 1'b0, 32'd0, 8'h00, 64'h42);
   endtask

   task automatic test_random();
      int idle_mode[4][2] = '{'{0, 0}, '{59, 0}, '{0, 59}, '{8, 8}};
      int sent;
      int k;
      foreach (idle_mode[p]) begin
         sender_idle_pct = idle_mode[p][0];
         receiver_stall_pct = idle_mode[p][1];
         sent = 0;
         while (sent < 16) begin
            send_random_sequence(k);
            sent += k;
         end
      end
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
   endtask

   // The receiver holds off while long integers keep arriving, so the
   // encoder fills up and has to stall its input.
   task automatic test_backpressure();
      hold_left = 300;
      for (int i = 0; i < 20; i++) begin
         send_word(OP_INT, 1'b0, $urandom, 8'($urandom), {1'b1, 63'($urandom)});
      end
   endtask

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_bytes.size() == 0) begin
            $display("%0t: unexpected word: expected none, actual byte %h last %b",
                     $time, rsp_tdata, rsp_tlast);
            mismatches++;
         end else begin
            expected_byte = pending_bytes.pop_front();
            if (rsp_tdata !== expected_byte.out_byte) begin
               $display("%0t: byte mismatch: expected %h, actual %h",
                        $time, expected_byte.out_byte, rsp_tdata);
               mismatches++;
            end
            if (rsp_tlast !== expected_byte.last_of_run) begin
               $display("%0t: last mismatch: expected %b, actual %b",
                        $time, expected_byte.last_of_run, rsp_tlast);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_integers();
      test_strings();
      test_lists();
      test_unused_operation();
      test_random();
      test_backpressure();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_bytes.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/rlpe_pkg.sv
rtl/rlpe_decode.sv
rtl/rlpe_count.sv
rtl/rlpe_serial.sv
rtl/rlp_item_encoder.sv
test/rlp_item_encoder_test.sv
